[design/clb_pkg.sv]
// clb_pkg: shared types, codes and helper functions for the control byte lexer
// used by clb_front, clb_queue, clb_back and control_byte_lexer_core
// no dependencies
`timescale 1ns / 1ps

package clb_pkg;

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // special byte values
  localparam logic [7:0] ByteBom    = 8'hEF;
  localparam logic [7:0] ByteEsc    = 8'h1B;
  localparam logic [7:0] ByteBndLo  = 8'h1C;
  localparam logic [7:0] ByteBndHi  = 8'h1F;
  localparam logic [7:0] ByteEccLo  = 8'hE0;
  localparam logic [7:0] ByteEccHi  = 8'hEE;
  localparam logic [7:0] ByteRefHi  = 8'h0F;
  localparam logic [7:0] BytePtrLo  = 8'h10;
  localparam logic [7:0] BytePrint  = 8'h40;
  localparam logic [7:0] ByteDot    = 8'h2E;
  localparam logic [7:0] ByteLparen = 8'h28;
  localparam logic [7:0] ByteRparen = 8'h29;
  localparam logic [7:0] ByteBraille = 8'h80;
  localparam logic [7:0] ByteAegean = 8'hC0;
  localparam logic [7:0] ByteSpace  = 8'h20;
  localparam logic [7:0] ByteMaxLevel = 8'hFF;

  // lexer mask bit positions
  localparam int MaskBom      = 0;
  localparam int MaskEsc      = 1;
  localparam int MaskBoundary = 2;
  localparam int MaskEcc      = 3;
  localparam int MaskRef      = 4;
  localparam int MaskPtr      = 5;
  localparam int MaskPrint    = 6;
  localparam int MaskDot      = 7;
  localparam int MaskLparen   = 8;
  localparam int MaskRparen   = 9;
  localparam int MaskBraille  = 10;
  localparam int MaskAegean   = 11;
  localparam int MaskW        = 12;

  // mixing constants
  localparam logic [7:0] MixStateMul = 8'd17;
  localparam logic [7:0] MixByteMul  = 8'd29;

  // digest constants
  localparam logic [31:0] FnvOffset = 32'd2166136261;
  localparam logic [31:0] FnvPrime  = 32'd16777619;

  typedef enum logic [1:0] {
    PlaneAscii   = 2'd0,
    PlaneBraille = 2'd1,
    PlaneAegean  = 2'd2,
    PlaneControl = 2'd3
  } clb_plane_e;

  typedef enum logic [3:0] {
    EmitBom      = 4'd0,
    EmitEsc      = 4'd1,
    EmitBoundary = 4'd2,
    EmitEcc      = 4'd3,
    EmitOpen     = 4'd4,
    EmitClose    = 4'd5,
    EmitDot      = 4'd6,
    EmitRef      = 4'd7,
    EmitPtr      = 4'd8,
    EmitAegean   = 4'd9,
    EmitBraille  = 4'd10,
    EmitAscii    = 4'd11,
    EmitUnknown  = 4'd12
  } clb_emit_e;

  typedef enum logic [1:0] {
    EccOk        = 2'd0,
    EccCorrected = 2'd1,
    EccDouble    = 2'd2
  } clb_ecc_e;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvOpen     = 3'd1,
    EvClose    = 3'd2,
    EvDot      = 3'd3,
    EvDangling = 3'd4,
    EvPair     = 3'd5,
    EvAtom     = 3'd6
  } clb_event_e;

  // classified transaction held in the queue
  typedef struct packed {
    logic [7:0]       data;
    logic [MaskW-1:0] mask;
    clb_plane_e       plane;
    clb_emit_e        emit;
    logic [2:0]       syn;
    clb_ecc_e         ecc_stat;
    logic [3:0]       ecc_nib;
  } clb_item_t;

  // finished result
  typedef struct packed {
    logic [MaskW-1:0] lex_mask;
    logic [1:0]       plane;
    logic [3:0]       emit_class;
    logic [10:0]      control_word;
    logic [2:0]       ecc_syndrome;
    logic [5:0]       mixed_state;
    logic [2:0]       winner_index;
    logic [31:0]      header_digest;
    logic [2:0]       dot_event;
    logic [7:0]       depth_out;
    logic [7:0]       pair_left_out;
    logic [7:0]       atom_out;
  } clb_result_t;

  typedef struct packed {
    logic [2:0] syn;
    clb_ecc_e   stat;
    logic [3:0] nib;
  } clb_secded_t;

  // one fnv-1a round
  function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

  // digest after the fixed six header bytes
  localparam logic [31:0] FnvPrefix =
    fnv_step(fnv_step(fnv_step(fnv_step(fnv_step(fnv_step(FnvOffset,
      8'h00), 8'h1B), 8'h1C), 8'h1D), 8'h1E), 8'h1F);

  // hamming(8,4) secded decode
  function automatic clb_secded_t secded(logic [7:0] c);
    clb_secded_t r;
    logic [2:0]  s;
    logic        par;
    logic [7:0]  fixed;
    s[0]  = c[0] ^ c[2] ^ c[4] ^ c[6];
    s[1]  = c[1] ^ c[2] ^ c[5] ^ c[6];
    s[2]  = c[3] ^ c[4] ^ c[5] ^ c[6];
    par   = ^c;
    fixed = c;
    r.stat = EccOk;
    if (s != 3'd0 && par) begin
      fixed  = c ^ (8'd1 << (s - 3'd1));
      r.stat = EccCorrected;
    end else if (s == 3'd0 && par) begin
      fixed  = c ^ 8'h80;
      r.stat = EccCorrected;
    end else if (s != 3'd0) begin
      r.stat = EccDouble;
    end
    r.syn = s;
    r.nib = {fixed[6], fixed[5], fixed[4], fixed[2]};
    return r;
  endfunction

  // residue modulo seven of a byte, by folding octal digits
  function automatic logic [2:0] mod7(logic [7:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = {3'd0, x[7:6]} + {2'd0, x[5:3]} + {2'd0, x[2:0]};
    s2 = {2'd0, s1[4:3]} + {1'd0, s1[2:0]};
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] x, int unsigned k);
    return (x << k) | (x >> (8 - k));
  endfunction

endpackage

[design/control_byte_lexer_core.sv]
// control_byte_lexer_core: top level of the control byte lexer
// instantiates clb_front, clb_queue and clb_back; depends on clb_pkg
`timescale 1ns / 1ps

// Each accepted byte yields exactly one result, in order: its lexer mask,
// plane and emit class, the control word after the update (sync, escape,
// boundary, secded status and nibble), the byte's syndrome, the new six-bit
// state, the residue modulo seven of the mixed value, the fnv-1a digest of the
// eight-byte header, and the list/dot/pair event with depth and atoms. A new
// byte is taken every cycle while the output is not stalled; the two-entry
// queue between the classifier and the execution side absorbs short stalls.
// A result passes the queue head, where the state update and first digest
// round are worked out, then the middle stage, where the final digest round
// is worked out on its way into the output register. The state update of the
// back side is the only recurrence.
module control_byte_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] lex_mask_o,
  output logic [1:0]  plane_o,
  output logic [3:0]  emit_class_o,
  output logic [10:0] control_word_o,
  output logic [2:0]  ecc_syndrome_o,
  output logic [5:0]  mixed_state_o,
  output logic [2:0]  winner_index_o,
  output logic [31:0] header_digest_o,
  output logic [2:0]  dot_event_o,
  output logic [7:0]  depth_out_o,
  output logic [7:0]  pair_left_out_o,
  output logic [7:0]  atom_out_o
);

  clb_pkg::clb_item_t   push_item, head_item;
  clb_pkg::clb_result_t res;
  logic                 q_full, q_push, q_pop, q_valid;

  // front: accept and classify
  clb_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  // decoupling queue
  clb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // back: state update, digest and output register
  clb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res)
  );

  // result fields onto ports
  assign lex_mask_o      = res.lex_mask;
  assign plane_o         = res.plane;
  assign emit_class_o    = res.emit_class;
  assign control_word_o  = res.control_word;
  assign ecc_syndrome_o  = res.ecc_syndrome;
  assign mixed_state_o   = res.mixed_state;
  assign winner_index_o  = res.winner_index;
  assign header_digest_o = res.header_digest;
  assign dot_event_o     = res.dot_event;
  assign depth_out_o     = res.depth_out;
  assign pair_left_out_o = res.pair_left_out;
  assign atom_out_o      = res.atom_out;

endmodule

[design/clb_front.sv]
// clb_front: accepts input bytes and classifies them into mask, plane, emit
// class and secded decode, then pushes them into the queue
// depends on clb_pkg
`timescale 1ns / 1ps

module clb_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output clb_pkg::clb_item_t q_item_o
);

  logic [7:0]                b;
  logic                      is_bom, is_esc, is_bnd, is_ecc;
  logic [clb_pkg::MaskW-1:0] m;
  clb_pkg::clb_secded_t      dec;

  assign b = in_byte_i;

  // handshake towards the queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // byte classes
  always_comb begin
    is_bom = (b == clb_pkg::ByteBom);
    is_esc = (b == clb_pkg::ByteEsc);
    is_bnd = (b >= clb_pkg::ByteBndLo) && (b <= clb_pkg::ByteBndHi);
    is_ecc = (b >= clb_pkg::ByteEccLo) && (b <= clb_pkg::ByteEccHi);

    m = '0;
    m[clb_pkg::MaskBom]      = is_bom;
    m[clb_pkg::MaskEsc]      = is_esc;
    m[clb_pkg::MaskBoundary] = is_bnd;
    m[clb_pkg::MaskEcc]      = is_ecc;
    m[clb_pkg::MaskRef]      = (b <= clb_pkg::ByteRefHi);
    m[clb_pkg::MaskPtr]      = (b >= clb_pkg::BytePtrLo) && (b <= clb_pkg::ByteBndHi);
    m[clb_pkg::MaskPrint]    = (b >= clb_pkg::BytePrint);
    m[clb_pkg::MaskDot]      = (b == clb_pkg::ByteDot);
    m[clb_pkg::MaskLparen]   = (b == clb_pkg::ByteLparen);
    m[clb_pkg::MaskRparen]   = (b == clb_pkg::ByteRparen);
    m[clb_pkg::MaskBraille]  = (b >= clb_pkg::ByteBraille) && (b < clb_pkg::ByteAegean);
    m[clb_pkg::MaskAegean]   = (b >= clb_pkg::ByteAegean);
  end

  // plane, emit class and ecc decode
  always_comb begin
    q_item_o.data = b;
    q_item_o.mask = m;

    priority if (is_bom || is_esc || is_bnd || is_ecc) begin
      q_item_o.plane = clb_pkg::PlaneControl;
    end else if (b >= clb_pkg::ByteAegean) begin
      q_item_o.plane = clb_pkg::PlaneAegean;
    end else if (b >= clb_pkg::ByteBraille) begin
      q_item_o.plane = clb_pkg::PlaneBraille;
    end else begin
      q_item_o.plane = clb_pkg::PlaneAscii;
    end

    priority if (m[clb_pkg::MaskBom]) begin
      q_item_o.emit = clb_pkg::EmitBom;
    end else if (m[clb_pkg::MaskEsc]) begin
      q_item_o.emit = clb_pkg::EmitEsc;
    end else if (m[clb_pkg::MaskBoundary]) begin
      q_item_o.emit = clb_pkg::EmitBoundary;
    end else if (m[clb_pkg::MaskEcc]) begin
      q_item_o.emit = clb_pkg::EmitEcc;
    end else if (m[clb_pkg::MaskLparen]) begin
      q_item_o.emit = clb_pkg::EmitOpen;
    end else if (m[clb_pkg::MaskRparen]) begin
      q_item_o.emit = clb_pkg::EmitClose;
    end else if (m[clb_pkg::MaskDot]) begin
      q_item_o.emit = clb_pkg::EmitDot;
    end else if (m[clb_pkg::MaskRef]) begin
      q_item_o.emit = clb_pkg::EmitRef;
    end else if (m[clb_pkg::MaskPtr]) begin
      q_item_o.emit = clb_pkg::EmitPtr;
    end else if (m[clb_pkg::MaskAegean]) begin
      q_item_o.emit = clb_pkg::EmitAegean;
    end else if (m[clb_pkg::MaskBraille]) begin
      q_item_o.emit = clb_pkg::EmitBraille;
    end else if (b < clb_pkg::ByteBraille) begin
      q_item_o.emit = clb_pkg::EmitAscii;
    end else begin
      q_item_o.emit = clb_pkg::EmitUnknown;
    end

    dec = clb_pkg::secded(b);
    if (is_ecc) begin
      q_item_o.syn      = dec.syn;
      q_item_o.ecc_stat = dec.stat;
      q_item_o.ecc_nib  = dec.nib;
    end else begin
      q_item_o.syn      = 3'd0;
      q_item_o.ecc_stat = clb_pkg::EccOk;
      q_item_o.ecc_nib  = 4'd0;
    end
  end

endmodule

[design/clb_queue.sv]
// clb_queue: small register queue of classified transactions between front and back
// depends on clb_pkg
`timescale 1ns / 1ps

module clb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  clb_pkg::clb_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output clb_pkg::clb_item_t item_o
);

  clb_pkg::clb_item_t               entry_q [clb_pkg::QueueDepth];
  logic [clb_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [clb_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [clb_pkg::QueuePtrW:0]      count_q, count_d;

  assign full_o  = (count_q == (clb_pkg::QueuePtrW + 1)'(clb_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[design/clb_back.sv]
// clb_back: carries out queued transactions: control plane, mixed state,
// list tracker and two-stage header digest, with an output register
// depends on clb_pkg
`timescale 1ns / 1ps

module clb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  clb_pkg::clb_item_t   q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output clb_pkg::clb_result_t result_o
);

  // architectural state
  logic [5:0]        mstate_q, mstate_d;
  logic [7:0]        tick_q, tick_d;
  logic              sync_q, sync_d;
  logic              esc_q, esc_d;
  logic [2:0]        bnd_q, bnd_d;
  clb_pkg::clb_ecc_e eccs_q, eccs_d;
  logic [3:0]        eccd_q, eccd_d;
  logic [7:0]        level_q, level_d;
  logic              pwait_q, pwait_d;
  logic [7:0]        pleft_q, pleft_d;
  logic [7:0]        patom_q, patom_d;
  logic              aseen_q, aseen_d;

  // stage a: state applied, first digest round done
  logic                 a_valid_q;
  clb_pkg::clb_result_t a_res_q, a_res_d;
  logic [31:0]          a_hash_q;

  // stage b: output register
  logic                 b_valid_q;
  clb_pkg::clb_result_t b_res_q, b_res_d;

  logic       a_ready, b_ready;
  logic [7:0] b;
  logic [7:0] mixed, ms8, x, d;
  logic [2:0] win;
  logic [5:0] curr;
  logic       is_atom;

  // pipeline flow
  assign b_ready = !b_valid_q || !out_stall_i;
  assign a_ready = !a_valid_q || b_ready;
  assign q_pop_o = q_valid_i && a_ready;

  assign out_valid_o = b_valid_q;
  assign result_o    = b_res_q;

  assign b = q_item_i.data;

  // control plane, mixed state and list tracker
  always_comb begin
    sync_d  = sync_q;
    esc_d   = esc_q;
    bnd_d   = bnd_q;
    eccs_d  = eccs_q;
    eccd_d  = eccd_q;
    level_d = level_q;
    pwait_d = pwait_q;
    pleft_d = pleft_q;
    patom_d = patom_q;
    aseen_d = aseen_q;

    // control plane
    priority if (q_item_i.mask[clb_pkg::MaskBom]) begin
      sync_d = 1'b1;
      esc_d  = 1'b0;
      bnd_d  = 3'd0;
      eccs_d = clb_pkg::EccOk;
      eccd_d = 4'd0;
    end else if (q_item_i.mask[clb_pkg::MaskEsc]) begin
      esc_d = !esc_q;
    end else if (q_item_i.mask[clb_pkg::MaskBoundary]) begin
      bnd_d = b[2:0] - 3'd3;
    end else if (q_item_i.mask[clb_pkg::MaskEcc]) begin
      eccs_d = q_item_i.ecc_stat;
      eccd_d = q_item_i.ecc_nib;
    end else begin
      sync_d = sync_q;
    end

    // mixed state
    tick_d = tick_q + 8'd1;
    ms8    = {2'b00, mstate_q};
    mixed  = (ms8 * clb_pkg::MixStateMul) ^ (b * clb_pkg::MixByteMul) ^ tick_d ^
             {4'd0, eccd_d};
    win    = clb_pkg::mod7(mixed);
    x      = ms8 ^ b;
    d      = clb_pkg::rol8(x, 1) ^ clb_pkg::rol8(x, 3) ^ clb_pkg::rol8(x, 6) ^
             {4'd0, eccd_d};
    curr   = mstate_q + b[5:0] + {3'd0, win} + d[5:0];
    mstate_d = curr;

    // list, dot and pair tracker
    is_atom = (b > clb_pkg::ByteSpace) && (b < clb_pkg::ByteBraille);
    a_res_d.dot_event     = clb_pkg::EvNone;
    a_res_d.depth_out     = level_q;
    a_res_d.pair_left_out = 8'd0;
    a_res_d.atom_out      = 8'd0;
    priority if (b == clb_pkg::ByteLparen) begin
      if (level_q != clb_pkg::ByteMaxLevel) begin
        level_d = level_q + 8'd1;
      end
      pwait_d = 1'b0;
      a_res_d.dot_event = clb_pkg::EvOpen;
      a_res_d.depth_out = level_d;
    end else if (b == clb_pkg::ByteRparen) begin
      if (level_q != 8'd0) begin
        level_d = level_q - 8'd1;
      end
      pwait_d = 1'b0;
      a_res_d.dot_event = clb_pkg::EvClose;
    end else if (b == clb_pkg::ByteDot) begin
      if (aseen_q) begin
        pleft_d = patom_q;
        pwait_d = 1'b1;
        a_res_d.dot_event     = clb_pkg::EvDot;
        a_res_d.pair_left_out = patom_q;
      end else begin
        pwait_d = 1'b0;
        a_res_d.dot_event = clb_pkg::EvDangling;
      end
    end else if (is_atom) begin
      if (pwait_q) begin
        a_res_d.dot_event     = clb_pkg::EvPair;
        a_res_d.pair_left_out = pleft_q;
        pwait_d = 1'b0;
      end else begin
        a_res_d.dot_event = clb_pkg::EvAtom;
      end
      a_res_d.atom_out = b;
      patom_d = b;
      aseen_d = 1'b1;
    end else begin
      a_res_d.dot_event = clb_pkg::EvNone;
    end

    // remaining result fields
    a_res_d.lex_mask      = q_item_i.mask;
    a_res_d.plane         = q_item_i.plane;
    a_res_d.emit_class    = q_item_i.emit;
    a_res_d.control_word  = {eccd_d, eccs_d, bnd_d, esc_d, sync_d};
    a_res_d.ecc_syndrome  = q_item_i.syn;
    a_res_d.mixed_state   = curr;
    a_res_d.winner_index  = win;
    a_res_d.header_digest = 32'd0;
  end

  // final digest round over the new state byte
  always_comb begin
    b_res_d               = a_res_q;
    b_res_d.header_digest = clb_pkg::fnv_step(a_hash_q, {2'b00, a_res_q.mixed_state});
  end

  // state registers, advanced once per popped transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstate_q <= '0;
      tick_q   <= '0;
      sync_q   <= 1'b0;
      esc_q    <= 1'b0;
      bnd_q    <= '0;
      eccs_q   <= clb_pkg::EccOk;
      eccd_q   <= '0;
      level_q  <= '0;
      pwait_q  <= 1'b0;
      pleft_q  <= '0;
      patom_q  <= '0;
      aseen_q  <= 1'b0;
    end else if (q_pop_o) begin
      mstate_q <= mstate_d;
      tick_q   <= tick_d;
      sync_q   <= sync_d;
      esc_q    <= esc_d;
      bnd_q    <= bnd_d;
      eccs_q   <= eccs_d;
      eccd_q   <= eccd_d;
      level_q  <= level_d;
      pwait_q  <= pwait_d;
      pleft_q  <= pleft_d;
      patom_q  <= patom_d;
      aseen_q  <= aseen_d;
    end
  end

  // valid bits of the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= q_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // stage payloads: digest byte round in stage a, state round in stage b
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_res_q  <= a_res_d;
      a_hash_q <= clb_pkg::fnv_step(clb_pkg::FnvPrefix, b);
    end
    if (b_ready && a_valid_q) begin
      b_res_q <= b_res_d;
    end
  end

endmodule
